>>> src/hms_pkg.sv
package hms_pkg;

    localparam int MAX_SIDE = 129;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int IDX_W    = 8;
    localparam int FRAC_W   = 8;
    localparam int HEIGHT_W = 16;
    localparam int COORD_W  = 20;
    localparam int ROW_W    = HEIGHT_W + FRAC_W + 1;
    localparam int ACC_W    = HEIGHT_W + 2 * FRAC_W + 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        BL_HOLD,
        BL_ROW0_LO,
        BL_ROW0_HI,
        BL_ROW1_LO,
        BL_ROW1_HI,
        BL_COL_LO,
        BL_COL_HI
    } blend_op_t;

    typedef struct packed {
        blend_op_t          op;
        logic [FRAC_W-1:0]  u;
        logic [FRAC_W-1:0]  v;
    } blend_ctl_t;

endpackage

>>> src/hms_blend.sv
module hms_blend
    import hms_pkg::*;
(
    input  logic                       aclk,
    input  blend_ctl_t                 ctl,
    input  logic signed [HEIGHT_W-1:0] rd_data,
    output logic signed [HEIGHT_W-1:0] height
);

    logic signed [ROW_W-1:0]   h0_reg;
    logic signed [ROW_W-1:0]   h1_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ROW_W-1:0]   mul_a;
    logic signed [FRAC_W+1:0]  mul_w;
    logic signed [ROW_W+FRAC_W+1:0] prod;
    logic [FRAC_W:0]           u_lo;
    logic [FRAC_W:0]           v_lo;
    logic signed [ACC_W-1:0]   rnd;

    assign u_lo = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, ctl.u};
    assign v_lo = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, ctl.v};

    always_comb begin
        mul_a = '0;
        mul_w = '0;
        unique case (ctl.op)
            BL_ROW0_LO, BL_ROW1_LO: begin
                mul_a = ROW_W'(rd_data);
                mul_w = $signed({1'b0, u_lo});
            end
            BL_ROW0_HI, BL_ROW1_HI: begin
                mul_a = ROW_W'(rd_data);
                mul_w = $signed({2'b00, ctl.u});
            end
            BL_COL_LO: begin
                mul_a = h0_reg;
                mul_w = $signed({1'b0, v_lo});
            end
            BL_COL_HI: begin
                mul_a = h1_reg;
                mul_w = $signed({2'b00, ctl.v});
            end
            default: begin
                mul_a = '0;
                mul_w = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_w;

    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            BL_ROW0_LO: h0_reg  <= ROW_W'(prod);
            BL_ROW0_HI: h0_reg  <= h0_reg + ROW_W'(prod);
            BL_ROW1_LO: h1_reg  <= ROW_W'(prod);
            BL_ROW1_HI: h1_reg  <= h1_reg + ROW_W'(prod);
            BL_COL_LO:  acc_reg <= ACC_W'(prod);
            BL_COL_HI:  acc_reg <= acc_reg + ACC_W'(prod);
            default: begin
            end
        endcase
    end

    // round half up, drop 16 fraction bits
    assign rnd    = acc_reg + ACC_W'(1 << (2 * FRAC_W - 1));
    assign height = rnd[2*FRAC_W +: HEIGHT_W];

endmodule

>>> src/heightmap_bilinear_sampler.sv
// channel | ports                                             | direction
// s_      | s_valid s_ready s_opcode s_entry_row s_entry_column | in
//         | s_entry_height s_query_x s_query_z                   |
// m_      | m_valid m_ready m_height m_in_range                  | out
// cfg_    | cfg_wr_en cfg_wr_data (grid_side)                    | in
//
// Writes may follow back to back.
// A query on the grid steps through RD00, RD10, RD01, RD11, LAST, COL0, COL1 and DONE: four
// reads of the single-port height memory overlapped with six steps of one shared
// multiply-accumulate unit, then DONE loads the result register and returns to idle.
// A query off the grid goes straight to DONE. s_ready is low until the state is idle again.
// A query waits in its last state while the result register still holds an untaken item.
// Reset sets grid_side to 129 and empties the control; the height memory is not cleared.
module heightmap_bilinear_sampler
    import hms_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [7:0]                 cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [IDX_W-1:0]           s_entry_row,
    input  logic [IDX_W-1:0]           s_entry_column,
    input  logic signed [HEIGHT_W-1:0] s_entry_height,
    input  logic signed [COORD_W-1:0]  s_query_x,
    input  logic signed [COORD_W-1:0]  s_query_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [HEIGHT_W-1:0] m_height,
    output logic                       m_in_range
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD00,
        ST_RD10,
        ST_RD01,
        ST_RD11,
        ST_LAST,
        ST_COL0,
        ST_COL1,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [7:0]                 grid_side_reg;
    logic [ADDR_W-1:0]          base0_reg;
    logic [ADDR_W-1:0]          base1_reg;
    logic [IDX_W-1:0]           j0_reg;
    logic [IDX_W-1:0]           j1_reg;
    logic [FRAC_W-1:0]          u_reg;
    logic [FRAC_W-1:0]          v_reg;
    logic                       in_range_reg;
    logic                       m_valid_reg;
    logic signed [HEIGHT_W-1:0] m_height_reg;
    logic                       m_in_range_reg;
    logic signed [HEIGHT_W-1:0] rd_data_reg;
    logic signed [HEIGHT_W-1:0] mem [DEPTH];

    logic [7:0]                 side;
    logic [7:0]                 side_m1;
    logic signed [8:0]          side_m1s;
    logic signed [COORD_W:0]    fx;
    logic signed [COORD_W:0]    fz;
    logic signed [COORD_W:0]    lim;
    logic                       q_on_grid;
    logic [IDX_W-1:0]           i0;
    logic [IDX_W-1:0]           i1;
    logic [IDX_W-1:0]           j0;
    logic [IDX_W-1:0]           j1;
    logic                       accept;
    logic                       out_free;
    logic                       wr_hit;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_addr;
    logic [ADDR_W-1:0]          wr_addr;
    blend_ctl_t                 bctl;
    logic signed [HEIGHT_W-1:0] blend_height;

    assign side     = (grid_side_reg > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : grid_side_reg;
    assign side_m1  = side - 8'd1;
    assign side_m1s = $signed({1'b0, side}) - 9'sd1;

    assign fx  = (COORD_W+1)'(s_query_x);
    assign fz  = (COORD_W+1)'(0) - (COORD_W+1)'(s_query_z);
    assign lim = (COORD_W+1)'($signed({side_m1s, 8'h00}));

    assign q_on_grid = !fx[COORD_W] && !fz[COORD_W] && (fx <= lim) && (fz <= lim);

    assign i0 = fx[FRAC_W +: IDX_W];
    assign j0 = fz[FRAC_W +: IDX_W];
    assign i1 = (i0 == side_m1) ? i0 : i0 + 8'd1;
    assign j1 = (j0 == side_m1) ? j0 : j0 + 8'd1;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign wr_hit   = (s_entry_row < side) && (s_entry_column < side);
    assign mem_we   = accept && (s_opcode == OP_WRITE) && wr_hit;
    assign wr_addr  = ADDR_W'(s_entry_row * MAX_SIDE) + ADDR_W'(s_entry_column);

    always_comb begin
        unique case (state_reg)
            ST_IDLE: mem_addr = wr_addr;
            ST_RD00: mem_addr = base0_reg + ADDR_W'(j0_reg);
            ST_RD10: mem_addr = base1_reg + ADDR_W'(j0_reg);
            ST_RD01: mem_addr = base0_reg + ADDR_W'(j1_reg);
            ST_RD11: mem_addr = base1_reg + ADDR_W'(j1_reg);
            default: mem_addr = '0;
        endcase
    end

    always_comb begin
        bctl.u = u_reg;
        bctl.v = v_reg;
        unique case (state_reg)
            ST_RD10: bctl.op = BL_ROW0_LO;
            ST_RD01: bctl.op = BL_ROW0_HI;
            ST_RD11: bctl.op = BL_ROW1_LO;
            ST_LAST: bctl.op = BL_ROW1_HI;
            ST_COL0: bctl.op = BL_COL_LO;
            ST_COL1: bctl.op = BL_COL_HI;
            default: bctl.op = BL_HOLD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= s_entry_height;
        end
        rd_data_reg <= mem[mem_addr];
    end

    hms_blend u_blend (
        .aclk    (aclk),
        .ctl     (bctl),
        .rd_data (rd_data_reg),
        .height  (blend_height)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            grid_side_reg <= 8'(MAX_SIDE);
            m_valid_reg   <= 1'b0;
            in_range_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                grid_side_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_opcode == OP_QUERY)) begin
                        in_range_reg <= q_on_grid;
                        base0_reg    <= ADDR_W'(i0 * MAX_SIDE);
                        base1_reg    <= ADDR_W'(i1 * MAX_SIDE);
                        j0_reg       <= j0;
                        j1_reg       <= j1;
                        u_reg        <= fx[FRAC_W-1:0];
                        v_reg        <= fz[FRAC_W-1:0];
                        state_reg    <= q_on_grid ? ST_RD00 : ST_DONE;
                    end
                end
                ST_RD00: state_reg <= ST_RD10;
                ST_RD10: state_reg <= ST_RD01;
                ST_RD01: state_reg <= ST_RD11;
                ST_RD11: state_reg <= ST_LAST;
                ST_LAST: state_reg <= ST_COL0;
                ST_COL0: state_reg <= ST_COL1;
                ST_COL1: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_height_reg   <= in_range_reg ? blend_height : '0;
                        m_in_range_reg <= in_range_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_height   = m_height_reg;
    assign m_in_range = m_in_range_reg;

    a_off_grid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !in_range_reg && out_free)
        |=> (m_height_reg == '0) && !m_in_range_reg && m_valid_reg)
        else $error("off-grid query did not give zero height");

    a_query_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_opcode == OP_QUERY && q_on_grid) |-> ##8 (state_reg == ST_DONE))
        else $error("on-grid query did not reach the done state in time");

    a_read_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD00 || state_reg == ST_RD10 || state_reg == ST_RD01
         || state_reg == ST_RD11) |-> (mem_addr < ADDR_W'(DEPTH)))
        else $error("corner read address beyond the height memory");

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !mem_we)
        else $error("height write while a query is reading");

endmodule

>>> tb/heightmap_bilinear_sampler_tb.sv
module heightmap_bilinear_sampler_tb
    import hms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 105;

    typedef struct {
        logic                       opcode;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic signed [HEIGHT_W-1:0] hgt;
        logic signed [COORD_W-1:0]  qx;
        logic signed [COORD_W-1:0]  qz;
    } sampler_cmd_t;

    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        logic                       in_range;
        longint unsigned            stamp;
    } height_sample_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [7:0]                 cfg_wr_data = 8'd0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_opcode = OP_WRITE;
    logic [IDX_W-1:0]           s_entry_row = '0;
    logic [IDX_W-1:0]           s_entry_column = '0;
    logic signed [HEIGHT_W-1:0] s_entry_height = '0;
    logic signed [COORD_W-1:0]  s_query_x = '0;
    logic signed [COORD_W-1:0]  s_query_z = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [HEIGHT_W-1:0] m_height;
    logic                       m_in_range;

    sampler_cmd_t    sampler_cmds[$];
    sampler_cmd_t    cur_cmd;
    height_sample_t  expected_samples[$];
    height_sample_t  got_sample;

    logic signed [HEIGHT_W-1:0] height_grid [0:DEPTH-1];
    bit                         gen_filled [0:DEPTH-1];
    int                         side_cfg = MAX_SIDE;
    int                         gen_count = 0;
    int                         idle_s = 13;
    int                         idle_m = 47;
    int                         mismatches = 0;

    heightmap_bilinear_sampler DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_entry_row    (s_entry_row),
        .s_entry_column (s_entry_column),
        .s_entry_height (s_entry_height),
        .s_query_x      (s_query_x),
        .s_query_z      (s_query_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_height       (m_height),
        .m_in_range     (m_in_range)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void sample_height(input logic signed [COORD_W-1:0] qx,
                                          input logic signed [COORD_W-1:0] qz,
                                          output logic signed [HEIGHT_W-1:0] h,
                                          output logic inr);
        longint fx, fz, lim, u, v, i0, j0, i1, j1;
        longint c00, c10, c01, c11, h0, h1, acc, res;
        fx = qx;
        fz = qz;
        fz = -fz;
        lim = (longint'(side_cfg) - 1) * 256;
        if (fx < 0 || fz < 0 || fx > lim || fz > lim) begin
            h = '0;
            inr = 1'b0;
            return;
        end
        i0 = fx >>> 8;
        j0 = fz >>> 8;
        u = fx & 255;
        v = fz & 255;
        i1 = (i0 + 1 > side_cfg - 1) ? side_cfg - 1 : i0 + 1;
        j1 = (j0 + 1 > side_cfg - 1) ? side_cfg - 1 : j0 + 1;
        c00 = height_grid[i0 * MAX_SIDE + j0];
        c10 = height_grid[i1 * MAX_SIDE + j0];
        c01 = height_grid[i0 * MAX_SIDE + j1];
        c11 = height_grid[i1 * MAX_SIDE + j1];
        h0 = c00 * (256 - u) + c10 * u;
        h1 = c01 * (256 - u) + c11 * u;
        acc = h0 * (256 - v) + h1 * v;
        res = (acc + 64'sd32768) >>> 16;
        h = res[HEIGHT_W-1:0];
        inr = 1'b1;
    endfunction

    function automatic void absorb_item(input sampler_cmd_t cmd);
        height_sample_t exp_s;
        if (cmd.opcode == OP_WRITE) begin
            if (int'(cmd.row) < side_cfg && int'(cmd.col) < side_cfg)
                height_grid[int'(cmd.row) * MAX_SIDE + int'(cmd.col)] = cmd.hgt;
        end else begin
            sample_height(cmd.qx, cmd.qz, exp_s.height, exp_s.in_range);
            exp_s.stamp = $time;
            expected_samples.push_back(exp_s);
        end
    endfunction

    task automatic push_write(input int r, input int c, input int h);
        sampler_cmd_t cmd;
        cmd.opcode = OP_WRITE;
        cmd.row = IDX_W'(r);
        cmd.col = IDX_W'(c);
        cmd.hgt = HEIGHT_W'(h);
        cmd.qx = COORD_W'($urandom);
        cmd.qz = COORD_W'($urandom);
        sampler_cmds.push_back(cmd);
        gen_count++;
        if (r < side_cfg && c < side_cfg) begin
            gen_filled[r * MAX_SIDE + c] = 1'b1;
        end
    endtask

    // fill any unwritten corner before the query reads it
    task automatic push_query(input int x, input int z);
        sampler_cmd_t cmd;
        int fx, fz, lim, i0, j0, i1, j1;
        cmd.opcode = OP_QUERY;
        cmd.row = IDX_W'($urandom);
        cmd.col = IDX_W'($urandom);
        cmd.hgt = HEIGHT_W'($urandom);
        cmd.qx = COORD_W'(x);
        cmd.qz = COORD_W'(z);
        fx = cmd.qx;
        fz = cmd.qz;
        fz = -fz;
        lim = (side_cfg - 1) * 256;
        if (!(fx < 0 || fz < 0 || fx > lim || fz > lim)) begin
            i0 = fx >>> 8;
            j0 = fz >>> 8;
            i1 = (i0 + 1 > side_cfg - 1) ? side_cfg - 1 : i0 + 1;
            j1 = (j0 + 1 > side_cfg - 1) ? side_cfg - 1 : j0 + 1;
            if (!gen_filled[i0 * MAX_SIDE + j0]) push_write(i0, j0, $urandom);
            if (!gen_filled[i1 * MAX_SIDE + j0]) push_write(i1, j0, $urandom);
            if (!gen_filled[i0 * MAX_SIDE + j1]) push_write(i0, j1, $urandom);
            if (!gen_filled[i1 * MAX_SIDE + j1]) push_write(i1, j1, $urandom);
        end
        sampler_cmds.push_back(cmd);
        gen_count++;
    endtask

    task automatic random_phase(input int n);
        int start, kind, lim, r, c, edge_off, on_grid;
        start = gen_count;
        while (gen_count - start < n) begin
            kind = $urandom_range(0, 99);
            lim = (side_cfg - 1) * 256;
            on_grid = (side_cfg > 0) ? $urandom_range(0, lim) : 0;
            if (kind < 25) begin
                if (side_cfg > 0 && $urandom_range(0, 9) < 7) begin
                    r = $urandom_range(0, side_cfg - 1);
                    c = $urandom_range(0, side_cfg - 1);
                end else begin
                    r = $urandom_range(0, 255);
                    c = $urandom_range(0, 255);
                end
                push_write(r, c, $urandom);
            end else if (kind < 80 && side_cfg > 0) begin
                push_query($urandom_range(0, lim), -int'($urandom_range(0, lim)));
            end else if (kind < 90) begin
                edge_off = $urandom_range(0, 1) ? lim + int'($urandom_range(1, 300))
                                                : -int'($urandom_range(1, 300));
                if ($urandom_range(0, 1))
                    push_query(edge_off, -on_grid);
                else
                    push_query(on_grid, -edge_off);
            end else begin
                push_query($urandom, $urandom);
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (sampler_cmds.size() != 0 || s_valid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_side(input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 8'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        side_cfg = (val > MAX_SIDE) ? MAX_SIDE : val;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                absorb_item(cur_cmd);
            if (!s_valid || s_ready) begin
                if (sampler_cmds.size() != 0 && $urandom_range(0, 99) >= idle_s) begin
                    cur_cmd = sampler_cmds.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= cur_cmd.opcode;
                    s_entry_row <= cur_cmd.row;
                    s_entry_column <= cur_cmd.col;
                    s_entry_height <= cur_cmd.hgt;
                    s_query_x <= cur_cmd.qx;
                    s_query_z <= cur_cmd.qz;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0 || expected_samples[0].stamp >= $time) begin
                    $error("unexpected item: height %0d in_range %0b", m_height, m_in_range);
                    mismatches++;
                end else begin
                    got_sample = expected_samples.pop_front();
                    if (m_height !== got_sample.height) begin
                        $error("height: expected %0d, actual %0d", got_sample.height, m_height);
                        mismatches++;
                    end
                    if (m_in_range !== got_sample.in_range) begin
                        $error("in_range: expected %0b, actual %0b",
                               got_sample.in_range, m_in_range);
                        mismatches++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= idle_m);
        end
    end

    initial begin
        int cfg_vals [8];
        cfg_vals = '{2, 255, 1, 0, $urandom_range(3, 128), 130, $urandom_range(2, 20), 129};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        push_write(0, 0, -32768);
        push_write(0, 128, 32767);
        push_write(128, 0, 32767);
        push_write(128, 128, -32768);
        push_write(1, 0, 32767);
        push_write(0, 1, 32767);
        push_write(1, 1, -32768);
        push_write(129, 0, 1);
        push_write(0, 255, -1);
        push_write(255, 129, 12345);
        push_query(0, 0);
        push_query(128, -128);
        push_query(255, -1);
        push_query(128 * 256, -128 * 256);
        push_query(128 * 256, 0);
        push_query(0, -128 * 256);
        push_query(127 * 256 + 200, -(127 * 256 + 17));
        push_query(-1, 0);
        push_query(0, 1);
        push_query(128 * 256 + 1, 0);
        push_query(0, -(128 * 256 + 1));
        push_query(-524288, 524287);
        push_query(524287, -524288);
        random_phase(PHASE_ITEMS);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            set_side(cfg_vals[p]);
            if (p == 2) begin
                idle_s <= 47;
                idle_m <= 13;
            end else if (p == 5) begin
                idle_s <= 0;
                idle_m <= 0;
            end
            if (side_cfg == 1)
                push_query(0, 0);
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
